// ===== rtl/ssr_pkg.sv =====
`timescale 1ns / 1ps

package ssr_pkg;

  localparam int unsigned LevelW   = 16;
  localparam int unsigned AdcW     = 10;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned CntW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TACH_INC   = 3'd0,
    CFG_SP_OFFSET  = 3'd1,
    CFG_OUT_OFFSET = 3'd2,
    CFG_DUTY_LIMIT = 3'd3,
    CFG_UPD_DIV    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_TACH = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    logic [LevelW-1:0] tach_increment;
    logic [LevelW-1:0] setpoint_offset;
    logic [DutyW-1:0]  output_offset;
    logic [DutyW-1:0]  duty_limit;
    logic [CntW-1:0]   update_divide;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    tach_increment:  16'd358,
    setpoint_offset: 16'd450,
    output_offset:   8'd128,
    duty_limit:      8'd160,
    update_divide:   8'd64
  };

endpackage

// ===== rtl/ssr_if.sv =====
`timescale 1ns / 1ps

interface ssr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [ssr_pkg::AdcW-1:0]   adc_sample;

  modport source (output valid, output kind, output adc_sample, input ready);
  modport sink   (input valid, input kind, input adc_sample, output ready);
  modport monitor (input valid, input kind, input adc_sample, input ready);
endinterface

interface ssr_out_if;
  logic                       valid;
  logic                       ready;
  logic [ssr_pkg::DutyW-1:0]  pwm_duty;
  logic [ssr_pkg::LevelW-1:0] tach_level;

  modport source (output valid, output pwm_duty, output tach_level, input ready);
  modport sink   (input valid, input pwm_duty, input tach_level, output ready);
  modport monitor (input valid, input pwm_duty, input tach_level, input ready);
endinterface

// ===== rtl/ssr_cfg.sv =====
`timescale 1ns / 1ps

module ssr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output ssr_pkg::cfg_t                 cfg_o
);
  import ssr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TACH_INC:   cfg_d.tach_increment  = cfg_wdata_i[LevelW-1:0];
        CFG_SP_OFFSET:  cfg_d.setpoint_offset = cfg_wdata_i[LevelW-1:0];
        CFG_OUT_OFFSET: cfg_d.output_offset   = cfg_wdata_i[DutyW-1:0];
        CFG_DUTY_LIMIT: cfg_d.duty_limit      = cfg_wdata_i[DutyW-1:0];
        CFG_UPD_DIV:    cfg_d.update_divide   = cfg_wdata_i[CntW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ssr_law.sv =====
`timescale 1ns / 1ps

module ssr_law (
  input  logic [ssr_pkg::LevelW-1:0] level_i,
  input  logic [ssr_pkg::AdcW-1:0]   adc_i,
  input  ssr_pkg::cfg_t              cfg_i,
  output logic [ssr_pkg::LevelW-1:0] level_o,
  output logic [ssr_pkg::DutyW-1:0]  duty_o
);
  import ssr_pkg::*;

  logic [LevelW-1:0]        decayed;
  logic [LevelW-1:0]        setpoint;
  logic [LevelW-1:0]        diff;
  logic signed [LevelW:0]   rounded;
  logic signed [LevelW-1:0] half;
  logic signed [LevelW:0]   err;
  logic signed [LevelW:0]   limit_s;

  // ~0.9 decay by alternating shift terms, modulo 2^16
  assign decayed = level_i - (level_i >> 3) + (level_i >> 5) - (level_i >> 7)
                 + (level_i >> 9) - (level_i >> 11) + (level_i >> 13)
                 - (level_i >> 15);

  assign setpoint = {{(LevelW-AdcW-2){1'b0}}, adc_i, 2'b00} + cfg_i.setpoint_offset;
  assign diff     = setpoint - decayed;

  // halve toward zero: bias negatives by one before the arithmetic shift
  assign rounded = $signed({diff[LevelW-1], diff}) + $signed({{LevelW{1'b0}}, diff[LevelW-1]});
  assign half    = rounded[LevelW:1];
  assign err     = $signed({half[LevelW-1], half})
                 + $signed({{(LevelW+1-DutyW){1'b0}}, cfg_i.output_offset});
  assign limit_s = $signed({{(LevelW+1-DutyW){1'b0}}, cfg_i.duty_limit});

  always_comb begin
    if (err > limit_s) begin
      duty_o = cfg_i.duty_limit;
    end else if (err[LevelW]) begin
      duty_o = '0;
    end else begin
      duty_o = err[DutyW-1:0];
    end
  end

  assign level_o = decayed;

endmodule

// ===== rtl/ssr_core.sv =====
`timescale 1ns / 1ps

module ssr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssr_pkg::cfg_t cfg_i,
  ssr_in_if.sink        in_if,
  ssr_out_if.source     out_if
);
  import ssr_pkg::*;

  logic              s1_valid_q;
  logic              s1_kind_q;
  logic [AdcW-1:0]   s1_adc_q;

  logic [LevelW-1:0] level_q, level_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   cnt_dec;

  logic              out_valid_q;
  logic [DutyW-1:0]  duty_q;
  logic [LevelW-1:0] tach_q;

  logic              out_free;
  logic              advance;
  logic              fire;
  logic              in_ready;
  logic [LevelW-1:0] decayed;
  logic [DutyW-1:0]  duty;

  ssr_law u_law (
    .level_i (level_q),
    .adc_i   (s1_adc_q),
    .cfg_i   (cfg_i),
    .level_o (decayed),
    .duty_o  (duty)
  );

  assign out_free = !out_valid_q || out_if.ready;
  assign advance  = s1_valid_q && out_free;
  assign in_ready = !s1_valid_q || out_free;
  assign cnt_dec  = cnt_q - 1'b1;

  always_comb begin
    level_d = level_q;
    cnt_d   = cnt_q;
    fire    = 1'b0;
    if (advance) begin
      if (s1_kind_q == KIND_TACH) begin
        level_d = level_q + cfg_i.tach_increment;
      end else begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          cnt_d   = cfg_i.update_divide;
          level_d = decayed;
          fire    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      level_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_if.valid;
      end
      level_q <= level_d;
      cnt_q   <= cnt_d;
      if (out_free) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_if.valid) begin
      s1_kind_q <= in_if.kind;
      s1_adc_q  <= in_if.adc_sample;
    end
    if (fire) begin
      duty_q <= duty;
      tach_q <= decayed;
    end
  end

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_q;
  assign out_if.pwm_duty   = duty_q;
  assign out_if.tach_level = tach_q;

endmodule

// ===== rtl/spindle_speed_regulator_top.sv =====
// channel | dir | fields                      | transaction when
// in_if   | in  | kind, adc_sample            | valid && ready
// out_if  | out | pwm_duty, tach_level        | valid && ready
// cfg     | in  | cfg_idx_i, cfg_wdata_i      | cfg_we_i
//
// One transaction per cycle in if ready; input register, one logic stage, output register.
// A tick's result moves from the input register into the output register; stalls hold it.
// in_if.ready drops only while a stage holds an item and the sink holds off a valid result.
// Reset clears level, tick countdown and registers to defaults; no clearing pass.
`timescale 1ns / 1ps

module spindle_speed_regulator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ssr_in_if.sink                        in_if,
  ssr_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [ssr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssr_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import ssr_pkg::*;

  cfg_t cfg;

  ssr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

// ===== rtl/ssr_checker.sv =====
`timescale 1ns / 1ps

module ssr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_kind_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [ssr_pkg::DutyW-1:0]    out_duty_i,
  input logic [ssr_pkg::LevelW-1:0]   out_level_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_duty_i)
      && $stable(out_level_i))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_rise_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2) && $past(in_kind_i, 2))
    else $error("result without a tick transaction two cycles earlier");

endmodule

bind spindle_speed_regulator_top ssr_checker u_ssr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_kind_i   (in_if.kind),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_duty_i  (out_if.pwm_duty),
  .out_level_i (out_if.tach_level)
);

// ===== tb/spindle_speed_regulator_top_test.sv =====
`timescale 1ns / 1ps

module spindle_speed_regulator_top_test;
  import ssr_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldOffLen   = 300;
  localparam int unsigned MaxReported  = 10;

  typedef struct {
    logic [DutyW-1:0]  duty;
    logic [LevelW-1:0] level;
  } update_t;

  class duty_scoreboard;
    logic [LevelW-1:0] tach_inc;
    logic [LevelW-1:0] sp_off;
    logic [DutyW-1:0]  out_off;
    logic [DutyW-1:0]  duty_lim;
    logic [CntW-1:0]   upd_div;
    logic [LevelW-1:0] speed;
    logic [CntW-1:0]   countdown;
    update_t           pending_updates[$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      tach_inc   = CfgReset.tach_increment;
      sp_off     = CfgReset.setpoint_offset;
      out_off    = CfgReset.output_offset;
      duty_lim   = CfgReset.duty_limit;
      upd_div    = CfgReset.update_divide;
      speed      = '0;
      countdown  = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_TACH_INC:   tach_inc = val;
        CFG_SP_OFFSET:  sp_off = val;
        CFG_OUT_OFFSET: out_off = val[DutyW-1:0];
        CFG_DUTY_LIMIT: duty_lim = val[DutyW-1:0];
        CFG_UPD_DIV:    upd_div = val[CntW-1:0];
        default: ;
      endcase
    endfunction

    // ~0.9 decay by alternating shift terms, modulo 2^16
    function logic [LevelW-1:0] decayed(logic [LevelW-1:0] x);
      logic [31:0] acc;
      acc = 32'(x) - 32'(x >> 3) + 32'(x >> 5) - 32'(x >> 7) + 32'(x >> 9)
          - 32'(x >> 11) + 32'(x >> 13) - 32'(x >> 15);
      return acc[LevelW-1:0];
    endfunction

    function void note_item(kind_e kind, logic [AdcW-1:0] adc);
      logic [LevelW-1:0] setpoint;
      logic [LevelW-1:0] diff;
      int                err;
      update_t           upd;
      if (kind == KIND_TACH) begin
        speed = speed + tach_inc;
        return;
      end
      countdown = countdown - 1'b1;
      if (countdown != '0) return;
      countdown = upd_div;
      speed     = decayed(speed);
      setpoint  = LevelW'({adc, 2'b00}) + sp_off;
      diff      = setpoint - speed;
      err       = int'($signed(diff)) / 2;
      err       = err + int'(out_off);
      if (err > int'(duty_lim)) upd.duty = duty_lim;
      else if (err < 0) upd.duty = '0;
      else upd.duty = err[DutyW-1:0];
      upd.level = speed;
      pending_updates.push_back(upd);
    endfunction

    function void check_update(logic [DutyW-1:0] duty, logic [LevelW-1:0] level);
      update_t exp_upd;
      checked++;
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected update: duty %0d level %0d", duty, level);
        return;
      end
      exp_upd = pending_updates.pop_front();
      if (duty !== exp_upd.duty || level !== exp_upd.level) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("update mismatch: expected duty %0d level %0d, got duty %0d level %0d",
                   exp_upd.duty, exp_upd.level, duty, level);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  ssr_in_if  in_ch ();
  ssr_out_if out_ch ();

  spindle_speed_regulator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  duty_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_req;
  int unsigned hold_off_left;
  int unsigned cycle_count;
  int unsigned n_tach;
  int unsigned n_tick;
  int unsigned n_settings;
  int unsigned n_fail;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d updates outstanding",
               cycle_count, sb.pending_updates.size());
      $display("Verification failed");
      $finish;
    end
  end

  // monitor: sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) sb.check_update(out_ch.pwm_duty, out_ch.tach_level);
      if (in_ch.valid && in_ch.ready) begin
        if (kind_e'(in_ch.kind) == KIND_TACH) n_tach++;
        else n_tick++;
        sb.note_item(kind_e'(in_ch.kind), in_ch.adc_sample);
      end
    end
  end

  // result sink with random backpressure and requested long hold-off
  initial begin
    out_ch.ready  = 1'b0;
    hold_off_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req  = 1'b0;
        hold_off_left = HoldOffLen;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(kind_e kind, logic [AdcW-1:0] adc);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.adc_sample <= adc;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_random_item();
    kind_e kind;
    kind = ($urandom_range(99) < 60) ? KIND_TICK : KIND_TACH;
    send_item(kind, AdcW'($urandom_range(1023)));
  endtask

  // drop valid, wait for all updates, then let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending_updates.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_cfg(logic [15:0] tinc, logic [15:0] spo, logic [7:0] oo,
                           logic [7:0] lim, logic [7:0] div);
    write_reg(CFG_TACH_INC, tinc);
    write_reg(CFG_SP_OFFSET, spo);
    write_reg(CFG_OUT_OFFSET, CfgDataW'(oo));
    write_reg(CFG_DUTY_LIMIT, CfgDataW'(lim));
    write_reg(CFG_UPD_DIV, CfgDataW'(div));
    n_settings++;
  endtask

  task automatic write_spare_regs();
    for (int i = int'(CFG_UPD_DIV) + 1; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), CfgDataW'($urandom_range(65535)));
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_TACH;
    in_ch.adc_sample = '0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_TACH_INC;
    cfg_wdata        = '0;
    send_idle_pct    = 34;
    recv_idle_pct    = 63;
    hold_off_req     = 1'b0;
    rst_ni           = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: first update only after 256 ticks
    repeat (20) send_item(KIND_TACH, AdcW'($urandom_range(1023)));
    repeat (260) send_item(KIND_TICK, AdcW'($urandom_range(1023)));
    settle();

    // directed: field extremes, setpoint overflow, error wrap, clamps
    write_cfg(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'd1);
    send_item(KIND_TACH, '0);
    send_item(KIND_TICK, 10'h3FF);
    send_item(KIND_TACH, 10'h3FF);
    send_item(KIND_TICK, '0);
    settle();
    write_cfg(16'h0000, 16'h0000, 8'h00, 8'h00, 8'd1);
    send_item(KIND_TICK, '0);
    send_item(KIND_TICK, 10'h3FF);
    send_item(KIND_TACH, 10'h155);
    settle();
    write_cfg(16'h7FFF, 16'h0000, 8'h00, 8'hFF, 8'd1);
    send_item(KIND_TACH, 10'h2AA);
    send_item(KIND_TICK, '0);
    send_item(KIND_TACH, '0);
    send_item(KIND_TACH, '0);
    send_item(KIND_TICK, 10'h3FF);
    settle();
    write_cfg(16'h8000, 16'h8000, 8'd128, 8'd100, 8'd0);
    send_item(KIND_TACH, 10'h3FF);
    send_item(KIND_TICK, 10'h3FF);
    send_item(KIND_TICK, 10'h001);
    settle();
    write_spare_regs();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 34; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        settle();
        case (s)
          0: begin
            write_cfg(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(4, 1)));
            write_spare_regs();
          end
          1: write_cfg(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'd1);
          2: write_cfg(16'($urandom_range(2000)), 16'($urandom_range(3000)),
                       8'($urandom_range(255)), 8'($urandom_range(255)), 8'd2);
          default: write_cfg(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             (mode == 0) ? 8'd255 : (mode == 1) ? 8'd0
                                                              : 8'($urandom_range(8, 1)));
        endcase
        if (mode == 2 && s == 0) begin
          // long sink stall with updates on every tick to back up the pipe
          write_reg(CFG_UPD_DIV, CfgDataW'(1));
          hold_off_req = 1'b1;
          repeat (40) send_item(KIND_TICK, AdcW'($urandom_range(1023)));
          settle();
          write_reg(CFG_UPD_DIV, CfgDataW'($urandom_range(4, 1)));
        end
        repeat (130) send_random_item();
      end
    end

    settle();
    n_fail = sb.mismatches + sb.pending_updates.size();
    $display("Run covered %0d tach edges and %0d ticks over %0d register settings,",
             n_tach, n_tick, n_settings);
    $display("with %0d control updates checked and %0d mismatches.", sb.checked, n_fail);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== spindle_speed_regulator_top.f =====
rtl/ssr_pkg.sv
rtl/ssr_if.sv
rtl/ssr_cfg.sv
rtl/ssr_law.sv
rtl/ssr_core.sv
rtl/spindle_speed_regulator_top.sv
rtl/ssr_checker.sv
tb/spindle_speed_regulator_top_test.sv
